// File: sv/tms_pkg.sv
// Shared types, codes and helpers for the Turing machine step core.
package tms_pkg;

  localparam int STATE_COUNT = 64;
  localparam int TAPE_DEPTH  = 512;
  localparam int RULE_SLOTS  = STATE_COUNT * 4;
  localparam int STATE_W     = 6;
  localparam int HEAD_W      = 9;
  localparam int LEN_W       = 10;
  localparam int STEP_W      = 20;
  localparam int SLOT_W      = $clog2(RULE_SLOTS);

  typedef enum logic [1:0] {
    ACT_RULE    = 2'd0,
    ACT_CELL    = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_STEP    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_STEPPED  = 3'd1,
    ST_HALTRULE = 3'd2,
    ST_NORULE   = 3'd3,
    ST_LIMIT    = 3'd4,
    ST_HALTED   = 3'd5
  } status_t;

  localparam logic [1:0] MOVE_RIGHT = 2'd1;
  localparam logic [1:0] MOVE_LEFT  = 2'd2;
  localparam logic [1:0] SYM_BLANK  = 2'd2;
  localparam logic [1:0] SYM_BAD    = 2'd3;

  localparam logic [1:0] REG_START  = 2'd0;
  localparam logic [1:0] REG_LENGTH = 2'd1;
  localparam logic [1:0] REG_LIMIT  = 2'd2;

  typedef struct packed {
    logic [STATE_W-1:0] start_state;
    logic [LEN_W-1:0]   tape_length;
    logic [STEP_W-1:0]  step_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         wr_sym;
    logic [1:0]         move;
    logic [STATE_W-1:0] next_state;
    logic               halts;
  } rule_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SYM  = 3'b010,
    S_EXEC = 3'b100
  } fsm_t;

  function automatic logic [1:0] sym_norm(input logic [1:0] v);
    sym_norm = (v == SYM_BAD) ? SYM_BLANK : v;
  endfunction

endpackage

// File: sv/tms_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module tms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/tms_cfg.sv
// APB configuration registers: start state, tape length and step limit.
module tms_cfg
  import tms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_state <= '0;
      cfg.tape_length <= LEN_W'(TAPE_DEPTH);
      cfg.step_limit  <= STEP_W'(1000000);
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_START:  cfg.start_state <= pwdata[STATE_W-1:0];
        REG_LENGTH: cfg.tape_length <= pwdata[LEN_W-1:0];
        REG_LIMIT:  cfg.step_limit  <= pwdata[STEP_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_START:  prdata = {{(32-STATE_W){1'b0}}, cfg.start_state};
      REG_LENGTH: prdata = {{(32-LEN_W){1'b0}}, cfg.tape_length};
      REG_LIMIT:  prdata = {{(32-STEP_W){1'b0}}, cfg.step_limit};
      default:    prdata = '0;
    endcase
  end

endmodule

// File: sv/turing_machine_step_core.sv
// Top level: step sequencer around the rule table and tape memories.
//
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------------------------
//  command   | start / busy         | action, rule_*, cell_index, cell_value
//  result    | done (one cycle)     | status, current_state, head_position,
//            |                      | read_symbol, written_symbol, steps_taken
//  config    | APB psel/penable     | paddr, pwdata, prdata, pready
//
// A step reads the tape at the head, then the rule table, then writes the tape and updates the
// state; a step on a halted machine or at the step limit ends after the rule table read. Loads
// and restart do the tape read only. done is registered and rises on the return to idle; busy
// is low in that cycle, so the next transaction may start there. Reset clears all rule valid
// bits at once; the tape holds no reset value. The result receiver cannot stall.
module turing_machine_step_core
  import tms_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          action,
  input  logic [5:0]          rule_state,
  input  logic [1:0]          rule_symbol,
  input  logic [1:0]          rule_write,
  input  logic [1:0]          rule_move,
  input  logic [5:0]          rule_next_state,
  input  logic                rule_halts,
  input  logic [8:0]          cell_index,
  input  logic [1:0]          cell_value,
  output logic                done,
  output logic [2:0]          status,
  output logic [5:0]          current_state,
  output logic [8:0]          head_position,
  output logic [1:0]          read_symbol,
  output logic [1:0]          written_symbol,
  output logic [19:0]         steps_taken,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfg_t cfg;

  fsm_t               fsm, fsm_next;
  action_t            act_q;
  logic [STATE_W-1:0] machine_state;
  logic [HEAD_W-1:0]  head;
  logic [STEP_W-1:0]  steps;
  logic               halted;
  logic               fwd_hit;
  logic [1:0]         fwd_val;
  logic [1:0]         rd_q;
  logic [RULE_SLOTS-1:0] rule_vld;
  logic               rule_vld_q;

  logic               accept;
  logic [1:0]         rd_sym;
  logic [LEN_W-1:0]   len_m1;
  logic [HEAD_W-1:0]  head_mv;

  logic               tape_we;
  logic [HEAD_W-1:0]  tape_waddr;
  logic [1:0]         tape_wdata;
  logic [HEAD_W-1:0]  tape_raddr;
  logic [1:0]         tape_rdata;

  logic               rule_we;
  logic [SLOT_W-1:0]  rule_waddr;
  rule_t              rule_wdata;
  logic [SLOT_W-1:0]  rule_raddr;
  rule_t              rule_rdata;

  tms_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tms_ram #(.WIDTH(2), .DEPTH(TAPE_DEPTH)) u_tape (
    .clk   (clk),
    .we    (tape_we),
    .waddr (tape_waddr),
    .wdata (tape_wdata),
    .raddr (tape_raddr),
    .rdata (tape_rdata)
  );

  tms_ram #(.WIDTH($bits(rule_t)), .DEPTH(RULE_SLOTS)) u_rules (
    .clk   (clk),
    .we    (rule_we),
    .waddr (rule_waddr),
    .wdata (rule_wdata),
    .raddr (rule_raddr),
    .rdata (rule_rdata)
  );

  assign busy   = (fsm != S_IDLE);
  assign accept = start && !busy;
  assign rd_sym = fwd_hit ? fwd_val : tape_rdata;

  assign current_state = machine_state;
  assign head_position = head;
  assign steps_taken   = steps;

  always_comb begin
    if (cfg.tape_length == '0) begin
      len_m1 = '0;
    end else if (cfg.tape_length > LEN_W'(TAPE_DEPTH)) begin
      len_m1 = LEN_W'(TAPE_DEPTH - 1);
    end else begin
      len_m1 = cfg.tape_length - LEN_W'(1);
    end
  end

  always_comb begin
    case (rule_rdata.move)
      MOVE_RIGHT: head_mv = ({1'b0, head} >= len_m1) ? '0 : head + HEAD_W'(1);
      MOVE_LEFT:  head_mv = (head == '0) ? len_m1[HEAD_W-1:0] : head - HEAD_W'(1);
      default:    head_mv = head;
    endcase
  end

  always_comb begin
    rule_we    = accept && (action_t'(action) == ACT_RULE);
    rule_waddr = {rule_state, rule_symbol};
    rule_wdata = '{wr_sym:     sym_norm(rule_write),
                   move:       rule_move,
                   next_state: rule_next_state,
                   halts:      rule_halts};
    rule_raddr = {machine_state, rd_sym};

    tape_raddr = (action_t'(action) == ACT_RESTART) ? '0 : head;
    if (fsm == S_EXEC) begin
      tape_we    = rule_vld_q && !rule_rdata.halts;
      tape_waddr = head;
      tape_wdata = rule_rdata.wr_sym;
    end else begin
      tape_we    = accept && (action_t'(action) == ACT_CELL);
      tape_waddr = cell_index;
      tape_wdata = sym_norm(cell_value);
    end
  end

  always_comb begin
    fsm_next = fsm;
    unique case (fsm)
      S_IDLE:  if (accept) fsm_next = S_SYM;
      S_SYM:   fsm_next = (act_q == ACT_STEP && !halted && steps < cfg.step_limit)
                          ? S_EXEC : S_IDLE;
      S_EXEC:  fsm_next = S_IDLE;
      default: fsm_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm           <= S_IDLE;
      machine_state <= '0;
      head          <= '0;
      steps         <= '0;
      halted        <= 1'b0;
      rule_vld      <= '0;
      done          <= 1'b0;
    end else begin
      fsm  <= fsm_next;
      done <= 1'b0;
      if (rule_we) begin
        rule_vld[rule_waddr] <= 1'b1;
      end
      unique case (fsm)
        S_IDLE: begin
          if (accept && action_t'(action) == ACT_RESTART) begin
            machine_state <= cfg.start_state;
            head          <= '0;
            steps         <= '0;
            halted        <= 1'b0;
          end
        end
        S_SYM: begin
          if (fsm_next == S_IDLE) begin
            done <= 1'b1;
            if (act_q == ACT_STEP && !halted) begin
              halted <= 1'b1;
            end
          end
        end
        S_EXEC: begin
          done  <= 1'b1;
          steps <= steps + STEP_W'(1);
          if (!rule_vld_q || rule_rdata.halts) begin
            halted <= 1'b1;
          end else begin
            head          <= head_mv;
            machine_state <= rule_rdata.next_state;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_q   <= action_t'(action);
      fwd_hit <= (action_t'(action) == ACT_CELL) && (cell_index == head);
      fwd_val <= sym_norm(cell_value);
    end
    if (fsm == S_SYM) begin
      rd_q       <= rd_sym;
      rule_vld_q <= rule_vld[rule_raddr];
      read_symbol    <= rd_sym;
      written_symbol <= rd_sym;
      if (act_q != ACT_STEP) begin
        status <= ST_ACCEPTED;
      end else if (halted) begin
        status <= ST_HALTED;
      end else begin
        status <= ST_LIMIT;
      end
    end
    if (fsm == S_EXEC) begin
      read_symbol <= rd_q;
      if (!rule_vld_q) begin
        status         <= ST_NORULE;
        written_symbol <= rd_q;
      end else if (rule_rdata.halts) begin
        status         <= ST_HALTRULE;
        written_symbol <= rd_q;
      end else begin
        status         <= ST_STEPPED;
        written_symbol <= rule_rdata.wr_sym;
      end
    end
  end

endmodule

// File: bench/tb_turing_machine_step_core.sv
`timescale 1ns / 100ps
// Testbench for the Turing machine step core: directed table and random programs.
module tb_turing_machine_step_core
  import tms_pkg::*;
();

  localparam int RAND_ITEMS  = 850;
  localparam int QUIET_LIMIT = 4000;

  typedef struct packed {
    action_t     act;
    logic [5:0]  r_state;
    logic [1:0]  r_sym;
    logic [1:0]  r_wr;
    logic [1:0]  r_move;
    logic [5:0]  r_next;
    logic        r_halt;
    logic [8:0]  c_idx;
    logic [1:0]  c_val;
  } tm_cmd_t;

  typedef struct packed {
    status_t     st;
    logic [5:0]  state;
    logic [8:0]  head;
    logic [1:0]  rd;
    logic [1:0]  wr;
    logic [19:0] steps;
  } tm_result_t;

  typedef struct {
    logic        is_reg;
    logic [1:0]  reg_idx;
    logic [31:0] reg_val;
    tm_cmd_t     cmd;
    logic        typed;
    tm_result_t  want;
  } tm_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  action = '0;
  logic [5:0]  rule_state = '0;
  logic [1:0]  rule_symbol = '0;
  logic [1:0]  rule_write = '0;
  logic [1:0]  rule_move = '0;
  logic [5:0]  rule_next_state = '0;
  logic        rule_halts = 1'b0;
  logic [8:0]  cell_index = '0;
  logic [1:0]  cell_value = '0;
  logic        done;
  logic [2:0]  status;
  logic [5:0]  current_state;
  logic [8:0]  head_position;
  logic [1:0]  read_symbol;
  logic [1:0]  written_symbol;
  logic [19:0] steps_taken;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  turing_machine_step_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .rule_state(rule_state), .rule_symbol(rule_symbol), .rule_write(rule_write),
    .rule_move(rule_move), .rule_next_state(rule_next_state), .rule_halts(rule_halts),
    .cell_index(cell_index), .cell_value(cell_value), .done(done), .status(status),
    .current_state(current_state), .head_position(head_position),
    .read_symbol(read_symbol), .written_symbol(written_symbol), .steps_taken(steps_taken),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  logic        rule_ok  [RULE_SLOTS];
  rule_t       rule_mem [RULE_SLOTS];
  logic [1:0]  tape_img [TAPE_DEPTH];
  logic [5:0]  m_state = '0;
  logic [8:0]  m_head = '0;
  logic [19:0] m_steps = '0;
  logic        m_halted = 1'b0;
  logic [5:0]  c_start = '0;
  logic [9:0]  c_len = 10'd512;
  logic [19:0] c_limit = 20'd1000000;

  tm_result_t  pending_results[$];
  tm_row_t     rows[$];
  int          err_count = 0;
  int          items_sent = 0;
  int          burst_left = 1;
  int          quiet = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic note_mismatch(input string what, input longint exp_v,
                               input longint got_v);
    $display("MISMATCH %s: expected %0d, got %0d at %0t", what, exp_v, got_v, $realtime);
    err_count++;
  endtask

  function automatic tm_result_t tm_apply(input tm_cmd_t c);
    tm_result_t r;
    logic [SLOT_W-1:0] slot;
    rule_t rl;
    logic [9:0] len;
    logic [9:0] last;
    r.st = ST_ACCEPTED;
    r.rd = tape_img[m_head];
    r.wr = r.rd;
    case (c.act)
      ACT_RULE: begin
        slot = {c.r_state, c.r_sym};
        rl.wr_sym = (c.r_wr == SYM_BAD) ? SYM_BLANK : c.r_wr;
        rl.move = c.r_move;
        rl.next_state = c.r_next;
        rl.halts = c.r_halt;
        rule_ok[slot] = 1'b1;
        rule_mem[slot] = rl;
      end
      ACT_CELL: begin
        tape_img[c.c_idx] = (c.c_val == SYM_BAD) ? SYM_BLANK : c.c_val;
        r.rd = tape_img[m_head];
        r.wr = r.rd;
      end
      ACT_RESTART: begin
        m_state = c_start;
        m_head = '0;
        m_steps = '0;
        m_halted = 1'b0;
        r.rd = tape_img[0];
        r.wr = r.rd;
      end
      ACT_STEP: begin
        if (m_halted) begin
          r.st = ST_HALTED;
        end else if (m_steps >= c_limit) begin
          m_halted = 1'b1;
          r.st = ST_LIMIT;
        end else begin
          slot = {m_state, r.rd};
          rl = rule_mem[slot];
          m_steps = m_steps + 1'b1;
          if (!rule_ok[slot]) begin
            m_halted = 1'b1;
            r.st = ST_NORULE;
          end else if (rl.halts) begin
            m_halted = 1'b1;
            r.st = ST_HALTRULE;
          end else begin
            if (c_len == 0) len = 10'd1;
            else if (c_len > TAPE_DEPTH) len = 10'(TAPE_DEPTH);
            else len = c_len;
            last = len - 1'b1;
            r.wr = rl.wr_sym;
            tape_img[m_head] = r.wr;
            if (rl.move == MOVE_RIGHT) m_head = (m_head >= last) ? '0 : m_head + 1'b1;
            else if (rl.move == MOVE_LEFT) m_head = (m_head == 0) ? last[8:0] : m_head - 1'b1;
            m_state = rl.next_state;
            r.st = ST_STEPPED;
          end
        end
      end
    endcase
    r.state = m_state;
    r.head = m_head;
    r.steps = m_steps;
    return r;
  endfunction

  function automatic tm_cmd_t rnd_cmd();
    tm_cmd_t c;
    c.act = action_t'($urandom_range(0, 3));
    c.r_state = 6'($urandom_range(0, 63));
    c.r_sym = 2'($urandom_range(0, 3));
    c.r_wr = 2'($urandom_range(0, 3));
    c.r_move = 2'($urandom_range(0, 3));
    c.r_next = 6'($urandom_range(0, 63));
    c.r_halt = 1'($urandom_range(0, 1));
    c.c_idx = 9'($urandom_range(0, 511));
    c.c_val = 2'($urandom_range(0, 3));
    return c;
  endfunction

  function automatic tm_cmd_t mk_rule(input int s, input int y, input int w, input int mv,
                                      input int nx, input int h);
    tm_cmd_t c;
    c = rnd_cmd();
    c.act = ACT_RULE;
    c.r_state = s[5:0];
    c.r_sym = y[1:0];
    c.r_wr = w[1:0];
    c.r_move = mv[1:0];
    c.r_next = nx[5:0];
    c.r_halt = h[0];
    return c;
  endfunction

  function automatic tm_cmd_t mk_cell(input int idx, input int v);
    tm_cmd_t c;
    c = rnd_cmd();
    c.act = ACT_CELL;
    c.c_idx = idx[8:0];
    c.c_val = v[1:0];
    return c;
  endfunction

  function automatic tm_cmd_t mk_ctl(input action_t a);
    tm_cmd_t c;
    c = rnd_cmd();
    c.act = a;
    return c;
  endfunction

  function automatic tm_result_t mk_res(input status_t st, input int s, input int h,
                                        input int rd, input int wr, input int n);
    tm_result_t r;
    r.st = st;
    r.state = s[5:0];
    r.head = h[8:0];
    r.rd = rd[1:0];
    r.wr = wr[1:0];
    r.steps = n[19:0];
    return r;
  endfunction

  function automatic logic [31:0] pick_length();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'd2;
      3: return $urandom_range(3, 16);
      4: return $urandom_range(1, 512);
      5: return 32'd512;
      6: return $urandom_range(513, 1023);
      default: return 32'd1023;
    endcase
  endfunction

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return $urandom_range(1, 30);
      2: return $urandom_range(31, 5000);
      3: return 32'hFFFFF;
      4: return 32'd1000000;
      default: return $urandom_range(0, 32'hFFFFF);
    endcase
  endfunction

  task automatic new_burst();
    if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(60, 200);
    else burst_left = $urandom_range(1, 12);
  endtask

  task automatic send(input tm_cmd_t c, input logic typed, input tm_result_t want);
    tm_result_t r;
    start <= 1'b1;
    action <= c.act;
    rule_state <= c.r_state;
    rule_symbol <= c.r_sym;
    rule_write <= c.r_wr;
    rule_move <= c.r_move;
    rule_next_state <= c.r_next;
    rule_halts <= c.r_halt;
    cell_index <= c.c_idx;
    cell_value <= c.c_val;
    do @(posedge clk); while (busy);
    r = tm_apply(c);
    pending_results.push_back(typed ? want : r);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
      new_burst();
    end
  endtask

  task automatic settle();
    if (start) start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] mask;
    logic [31:0] got;
    mask = (idx == REG_START) ? 32'h3F : (idx == REG_LENGTH) ? 32'h3FF : 32'hFFFFF;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_START:  c_start = val[5:0];
      REG_LENGTH: c_len = val[9:0];
      default:    c_limit = val[19:0];
    endcase
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    if (got != (val & mask)) note_mismatch("register readback", val & mask, got);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic row_item(input tm_cmd_t c, input logic typed, input tm_result_t want);
    tm_row_t w;
    w.is_reg = 1'b0;
    w.reg_idx = '0;
    w.reg_val = '0;
    w.cmd = c;
    w.typed = typed;
    w.want = want;
    rows.push_back(w);
  endtask

  task automatic row_reg(input logic [1:0] idx, input logic [31:0] val);
    tm_row_t w;
    w.is_reg = 1'b1;
    w.reg_idx = idx;
    w.reg_val = val;
    w.cmd = '0;
    w.typed = 1'b0;
    w.want = '0;
    rows.push_back(w);
  endtask

  task automatic build_rows();
    row_item(mk_cell(0, 1), 1'b1, mk_res(ST_ACCEPTED, 0, 0, 1, 1, 0));
    row_item(mk_ctl(ACT_STEP), 1'b1, mk_res(ST_NORULE, 0, 0, 1, 1, 1));
    row_item(mk_ctl(ACT_STEP), 1'b1, mk_res(ST_HALTED, 0, 0, 1, 1, 1));
    row_item(mk_rule(0, 1, 0, MOVE_LEFT, 5, 0), 1'b1, mk_res(ST_ACCEPTED, 0, 0, 1, 1, 1));
    row_item(mk_ctl(ACT_RESTART), 1'b1, mk_res(ST_ACCEPTED, 0, 0, 1, 1, 0));
    row_item(mk_ctl(ACT_STEP), 1'b1, mk_res(ST_STEPPED, 5, 511, 1, 0, 1));
    row_item(mk_cell(511, SYM_BAD), 1'b1, mk_res(ST_ACCEPTED, 5, 511, 2, 2, 1));
    row_item(mk_rule(5, SYM_BLANK, SYM_BAD, MOVE_RIGHT, 63, 0), 1'b1,
             mk_res(ST_ACCEPTED, 5, 511, 2, 2, 1));
    row_item(mk_ctl(ACT_STEP), 1'b1, mk_res(ST_STEPPED, 63, 0, 2, 2, 2));
    row_item(mk_rule(63, 0, 1, 3, 0, 0), 1'b1, mk_res(ST_ACCEPTED, 63, 0, 0, 0, 2));
    row_item(mk_ctl(ACT_STEP), 1'b1, mk_res(ST_STEPPED, 0, 0, 0, 1, 3));
    row_item(mk_rule(0, 1, SYM_BLANK, MOVE_LEFT, 63, 1), 1'b1,
             mk_res(ST_ACCEPTED, 0, 0, 1, 1, 3));
    row_item(mk_ctl(ACT_STEP), 1'b1, mk_res(ST_HALTRULE, 0, 0, 1, 1, 4));
    row_item(mk_rule(0, SYM_BAD, 0, MOVE_RIGHT, 1, 0), 1'b0, '0);
    row_item(mk_cell(0, SYM_BAD), 1'b0, '0);
    row_reg(REG_LIMIT, 32'd0);
    row_item(mk_ctl(ACT_RESTART), 1'b1, mk_res(ST_ACCEPTED, 0, 0, 2, 2, 0));
    row_item(mk_ctl(ACT_STEP), 1'b1, mk_res(ST_LIMIT, 0, 0, 2, 2, 0));
    row_item(mk_ctl(ACT_STEP), 1'b1, mk_res(ST_HALTED, 0, 0, 2, 2, 0));
    row_reg(REG_START, 32'd63);
    row_reg(REG_LENGTH, 32'd0);
    row_reg(REG_LIMIT, 32'hFFFFF);
    row_item(mk_ctl(ACT_RESTART), 1'b1, mk_res(ST_ACCEPTED, 63, 0, 2, 2, 0));
    row_item(mk_rule(63, SYM_BLANK, 0, MOVE_LEFT, 63, 0), 1'b1,
             mk_res(ST_ACCEPTED, 63, 0, 2, 2, 0));
    row_item(mk_ctl(ACT_STEP), 1'b1, mk_res(ST_STEPPED, 63, 0, 2, 0, 1));
    row_item(mk_rule(63, 0, SYM_BLANK, MOVE_RIGHT, 62, 0), 1'b1,
             mk_res(ST_ACCEPTED, 63, 0, 0, 0, 1));
    row_item(mk_ctl(ACT_STEP), 1'b1, mk_res(ST_STEPPED, 62, 0, 0, 2, 2));
    row_item(mk_ctl(ACT_STEP), 1'b1, mk_res(ST_NORULE, 62, 0, 2, 2, 3));
    row_reg(REG_LENGTH, 32'd1023);
  endtask

  task automatic run_random();
    logic [5:0] prog [6];
    int nst;
    int base;
    int n;
    tm_cmd_t c;
    base = items_sent;
    while (items_sent - base < RAND_ITEMS) begin
      nst = $urandom_range(1, 6);
      foreach (prog[k]) prog[k] = 6'($urandom_range(0, 63));
      settle();
      reg_write(REG_START, ($urandom_range(0, 4) != 0) ? 32'(prog[0]) : $urandom_range(0, 63));
      reg_write(REG_LENGTH, pick_length());
      reg_write(REG_LIMIT, pick_limit());
      for (int s = 0; s < nst; s++) begin
        for (int y = 0; y < 3; y++) begin
          if ($urandom_range(0, 9) == 0) send(rnd_cmd(), 1'b0, '0);
          if ($urandom_range(0, 15) != 0) begin
            c = rnd_cmd();
            c.act = ACT_RULE;
            c.r_state = prog[s];
            c.r_sym = 2'(y);
            c.r_next = prog[$urandom_range(0, nst - 1)];
            c.r_halt = ($urandom_range(0, 24) == 0);
            send(c, 1'b0, '0);
          end
        end
      end
      repeat ($urandom_range(1, 3)) begin
        send(mk_ctl(ACT_RESTART), 1'b0, '0);
        n = $urandom_range(5, 60);
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(0, 7) == 0) send(rnd_cmd(), 1'b0, '0);
          else send(mk_ctl(ACT_STEP), 1'b0, '0);
          if (m_halted && $urandom_range(0, 2) != 0) break;
        end
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    tm_result_t w;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result with nothing pending, status", 0, status);
      end else begin
        w = pending_results.pop_front();
        if (status != w.st) note_mismatch("status", w.st, status);
        if (current_state != w.state) note_mismatch("current_state", w.state, current_state);
        if (head_position != w.head) note_mismatch("head_position", w.head, head_position);
        if (read_symbol != w.rd) note_mismatch("read_symbol", w.rd, read_symbol);
        if (written_symbol != w.wr) note_mismatch("written_symbol", w.wr, written_symbol);
        if (steps_taken != w.steps) note_mismatch("steps_taken", w.steps, steps_taken);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    tm_cmd_t c;
    foreach (rule_ok[k]) rule_ok[k] = 1'b0;
    new_burst();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // fill the tape from the head cell upwards
    for (int i = 0; i < TAPE_DEPTH; i++) begin
      c = mk_cell(i, $urandom_range(0, 3));
      send(c, 1'b0, '0);
    end
    build_rows();
    foreach (rows[k]) begin
      if (rows[k].is_reg) begin
        settle();
        reg_write(rows[k].reg_idx, rows[k].reg_val);
      end else begin
        send(rows[k].cmd, rows[k].typed, rows[k].want);
      end
    end
    run_random();
    settle();
    repeat (8) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
